// ===== rtl/queued_beep_pattern_generator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Queued beep pattern generator assertion macros
// Concurrent assertion shorthands used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef QUEUED_BEEP_PATTERN_GENERATOR_CORE_ASSERT_SVH
`define QUEUED_BEEP_PATTERN_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QBPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Queued beep pattern generator package
// Item types, register map, player state and player helper functions.
// ----------------------------------------------------------------------------
package qbpg_pkg;

  localparam int MS_W    = 16;
  localparam int COUNT_W = 8;
  localparam int LEVEL_W = 5;
  localparam int RECIP_W = 18;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TICK_MS_DEF     = 10;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0] REG_GAP_MS = '0;
  localparam logic [MS_W-1:0]   GAP_MS_RESET = 16'd100;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ENQUEUE = 1'b1;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic               cmd;
    logic [COUNT_W-1:0] beep_count;
    logic [MS_W-1:0]    on_ms;
    logic [MS_W-1:0]    off_ms;
  } in_item_t;

  typedef struct packed {
    logic               buzzer_on;
    logic               dropped;
    logic [LEVEL_W-1:0] queue_level;
    logic               busy_res;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MS_W-1:0]    on_t;
    logic [MS_W-1:0]    off_t;
  } entry_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ON   = 4'b0010,
    PH_OFF  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [MS_W-1:0]    ticks;
    logic [COUNT_W-1:0] beeps;
  } player_t;

  function automatic player_t start_gap(input logic [MS_W-1:0] gap_t,
                                        input logic [COUNT_W-1:0] beeps);
    player_t p;
    p.beeps = beeps;
    if (gap_t != '0) begin
      p.phase = PH_GAP;
      p.ticks = gap_t;
    end else begin
      p.phase = PH_IDLE;
      p.ticks = '0;
    end
    return p;
  endfunction

  function automatic player_t next_beep(input logic [COUNT_W-1:0] beeps,
                                        input logic [MS_W-1:0] on_t,
                                        input logic [MS_W-1:0] off_t,
                                        input logic [MS_W-1:0] gap_t);
    player_t p;
    if (beeps == '0) begin
      p = start_gap(gap_t, beeps);
    end else if (on_t != '0) begin
      p.phase = PH_ON;
      p.ticks = on_t;
      p.beeps = beeps - 1'b1;
    end else if (off_t != '0) begin
      p.phase = PH_OFF;
      p.ticks = off_t;
      p.beeps = beeps - 1'b1;
    end else begin
      p = start_gap(gap_t, '0);
    end
    return p;
  endfunction

endpackage

// ===== rtl/queued_beep_pattern_generator_core.sv =====
// ----------------------------------------------------------------------------
// Queued beep pattern generator
// Beep requests are queued in a FIFO; tick items advance a player that plays
// each request as on and off phases repeated beep_count times, then a quiet
// gap. One item is accepted every cycle unless a held result stalls the input,
// and its result appears in the output register on the following cycle; the rate
// is set by the single pass through the player logic and the queue head, which
// is kept readable each cycle by a registered-read RAM with a write bypass. Times
// are converted to ticks when a request is queued and when gap_ms is written.
// ----------------------------------------------------------------------------
module queued_beep_pattern_generator_core #(
  parameter int QUEUE_DEPTH = qbpg_pkg::QUEUE_DEPTH_DEF,
  parameter int TICK_MS     = qbpg_pkg::TICK_MS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  qbpg_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output qbpg_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [qbpg_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [qbpg_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [qbpg_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(qbpg_pkg::entry_t);
  localparam logic [qbpg_pkg::MS_W-1:0] GAP_TICKS_RESET =
    qbpg_pkg::MS_W'(qbpg_pkg::GAP_MS_RESET / TICK_MS);

  logic [AW-1:0]                rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [FW-1:0]                fill_r, fill_nxt;
  qbpg_pkg::player_t            ply_r, ply_nxt;
  logic [qbpg_pkg::MS_W-1:0]    on_t_r, on_t_nxt;
  logic [qbpg_pkg::MS_W-1:0]    off_t_r, off_t_nxt;
  logic [qbpg_pkg::MS_W-1:0]    gap_ms_r;
  logic [qbpg_pkg::MS_W-1:0]    gap_t_r;
  logic                         byp_r;
  qbpg_pkg::entry_t             byp_entry_r;
  logic                         out_valid_r;
  qbpg_pkg::out_item_t          out_data_r;

  logic                         in_acc;
  logic                         wr_en;
  logic                         dropped;
  qbpg_pkg::entry_t             wr_entry;
  qbpg_pkg::entry_t             head;
  logic [EW-1:0]                ram_rdata;
  logic [qbpg_pkg::MS_W-1:0]    on_t_in, off_t_in, gap_t_in;
  logic                         cfg_wr;

  qbpg_tick_div #(.TICK_MS(TICK_MS)) u_div_on (.ms(in_data.on_ms), .ticks(on_t_in));
  qbpg_tick_div #(.TICK_MS(TICK_MS)) u_div_off (.ms(in_data.off_ms), .ticks(off_t_in));
  qbpg_tick_div #(.TICK_MS(TICK_MS)) u_div_gap (
    .ms    (cfg_pwdata[qbpg_pkg::MS_W-1:0]),
    .ticks (gap_t_in)
  );

  assign wr_entry.count = in_data.beep_count;
  assign wr_entry.on_t  = on_t_in;
  assign wr_entry.off_t = off_t_in;

  qbpg_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wdata (wr_entry),
    .raddr (rd_ptr_nxt),
    .rdata (ram_rdata)
  );

  assign head     = byp_r ? byp_entry_r : qbpg_pkg::entry_t'(ram_rdata);
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    ply_nxt    = ply_r;
    on_t_nxt   = on_t_r;
    off_t_nxt  = off_t_r;
    dropped    = 1'b0;
    wr_en      = 1'b0;
    if (in_acc) begin
      if (in_data.cmd == qbpg_pkg::CMD_ENQUEUE) begin
        if (fill_r == FW'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          wr_en      = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
          fill_nxt   = fill_r + 1'b1;
        end
      end else if (ply_r.phase == qbpg_pkg::PH_IDLE) begin
        if (fill_r != '0) begin
          rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
          fill_nxt   = fill_r - 1'b1;
          on_t_nxt   = head.on_t;
          off_t_nxt  = head.off_t;
          ply_nxt    = qbpg_pkg::next_beep(head.count, head.on_t, head.off_t, gap_t_r);
        end
      end else if (ply_r.ticks <= qbpg_pkg::MS_W'(1)) begin
        case (ply_r.phase)
          qbpg_pkg::PH_ON: begin
            if (off_t_r != '0) begin
              ply_nxt.phase = qbpg_pkg::PH_OFF;
              ply_nxt.ticks = off_t_r;
            end else begin
              ply_nxt = qbpg_pkg::next_beep(ply_r.beeps, on_t_r, off_t_r, gap_t_r);
            end
          end
          qbpg_pkg::PH_OFF: begin
            ply_nxt = qbpg_pkg::next_beep(ply_r.beeps, on_t_r, off_t_r, gap_t_r);
          end
          default: begin
            ply_nxt.phase = qbpg_pkg::PH_IDLE;
            ply_nxt.ticks = '0;
          end
        endcase
      end else begin
        ply_nxt.ticks = ply_r.ticks - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      ply_r.phase <= qbpg_pkg::PH_IDLE;
      ply_r.ticks <= '0;
      ply_r.beeps <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
      ply_r    <= ply_nxt;
      byp_r    <= wr_en && (wr_ptr_r == rd_ptr_nxt);
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    on_t_r      <= on_t_nxt;
    off_t_r     <= off_t_nxt;
    byp_entry_r <= wr_entry;
    if (in_acc) begin
      out_data_r.buzzer_on   <= (ply_nxt.phase == qbpg_pkg::PH_ON);
      out_data_r.dropped     <= dropped;
      out_data_r.queue_level <= qbpg_pkg::level_t'(fill_nxt);
      out_data_r.busy_res    <= (ply_nxt.phase != qbpg_pkg::PH_IDLE);
    end
  end

  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite &
                  (cfg_paddr[qbpg_pkg::CFG_AW-1:2] == qbpg_pkg::REG_GAP_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_ms_r <= qbpg_pkg::GAP_MS_RESET;
      gap_t_r  <= GAP_TICKS_RESET;
    end else if (cfg_wr) begin
      gap_ms_r <= cfg_pwdata[qbpg_pkg::MS_W-1:0];
      gap_t_r  <= gap_t_in;
    end
  end

  assign cfg_prdata = (cfg_paddr[qbpg_pkg::CFG_AW-1:2] == qbpg_pkg::REG_GAP_MS) ?
                      qbpg_pkg::CFG_DW'(gap_ms_r) : '0;
  assign cfg_pready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/qbpg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qbpg_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/qbpg_tick_div.sv =====
// ----------------------------------------------------------------------------
// Millisecond to tick converter
// Exact truncating division of a 16-bit time by the tick period, done as a
// multiplication by a rounded-up reciprocal and a shift.
// ----------------------------------------------------------------------------
module qbpg_tick_div #(
  parameter int TICK_MS = qbpg_pkg::TICK_MS_DEF
) (
  input  logic [qbpg_pkg::MS_W-1:0] ms,
  output logic [qbpg_pkg::MS_W-1:0] ticks
);

  localparam int SH = qbpg_pkg::MS_W + $clog2(TICK_MS);
  localparam longint unsigned RECIP = ((64'd1 << SH) + TICK_MS - 1) / TICK_MS;
  localparam int PW = qbpg_pkg::MS_W + qbpg_pkg::RECIP_W;

  logic [qbpg_pkg::RECIP_W-1:0] recip;
  logic [PW-1:0]                prod;

  assign recip = qbpg_pkg::RECIP_W'(RECIP);
  assign prod  = PW'(ms) * PW'(recip);
  assign ticks = qbpg_pkg::MS_W'(prod >> SH);

endmodule

// ===== rtl/qbpg_checker.sv =====
// ----------------------------------------------------------------------------
// Queued beep pattern generator checker
// Port-level assertions on the item channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "queued_beep_pattern_generator_core_assert.svh"

module qbpg_checker #(
  parameter int QUEUE_DEPTH = qbpg_pkg::QUEUE_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input qbpg_pkg::out_item_t out_data
);

  localparam qbpg_pkg::level_t FULL_LEVEL = qbpg_pkg::level_t'(QUEUE_DEPTH);

  `QBPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "Stalled result item changed or vanished.")
  `QBPG_ASSERT_SAME(a_in_stall, in_stall, out_valid && out_stall, "Input stalled while the result register can move.")
  `QBPG_ASSERT_SAME(a_buzz_busy, out_valid && out_data.buzzer_on, out_data.busy_res, "Buzzer on while the player is idle.")
  `QBPG_ASSERT_SAME(a_drop_full, out_valid && out_data.dropped, out_data.queue_level == FULL_LEVEL, "Item dropped while the queue had room.")

endmodule

bind queued_beep_pattern_generator_core qbpg_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_qbpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/queued_beep_pattern_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Queued beep pattern generator testbench
// Drives tick and enqueue items into the core and predicts each status item
// with a cycle-free model of the request queue and the beep player. Results
// are checked field by field in order. The run goes through several quiet gap
// settings, random sender gaps and receiver stalls, a long receiver hold-off
// and a queue overflow.
// ----------------------------------------------------------------------------
module queued_beep_pattern_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TICK_MS     = qbpg_pkg::TICK_MS_DEF;
  localparam int QDEPTH      = qbpg_pkg::QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 80;
  localparam logic [qbpg_pkg::CFG_AW-3:0] REG_SPARE = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  qbpg_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  qbpg_pkg::out_item_t           out_data;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [qbpg_pkg::CFG_AW-1:0]   cfg_paddr = '0;
  logic [qbpg_pkg::CFG_DW-1:0]   cfg_pwdata = '0;
  logic [qbpg_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                          cfg_pready;

  qbpg_pkg::entry_t              waiting_requests[$];
  qbpg_pkg::phase_t              pl_phase = qbpg_pkg::PH_IDLE;
  logic [qbpg_pkg::MS_W-1:0]     pl_ticks = '0;
  logic [qbpg_pkg::COUNT_W-1:0]  pl_beeps = '0;
  logic [qbpg_pkg::MS_W-1:0]     cur_on_t = '0;
  logic [qbpg_pkg::MS_W-1:0]     cur_off_t = '0;
  logic [qbpg_pkg::MS_W-1:0]     gap_ms_m = qbpg_pkg::GAP_MS_RESET;

  qbpg_pkg::in_item_t  pending_items[$];
  qbpg_pkg::out_item_t expected_status[$];
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;

  queued_beep_pattern_generator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [qbpg_pkg::MS_W-1:0] ms_to_ticks(logic [qbpg_pkg::MS_W-1:0] ms);
    return qbpg_pkg::MS_W'(ms / TICK_MS);
  endfunction

  function automatic void begin_gap();
    logic [qbpg_pkg::MS_W-1:0] t;
    t = ms_to_ticks(gap_ms_m);
    if (t != '0) begin
      pl_phase = qbpg_pkg::PH_GAP;
      pl_ticks = t;
    end else begin
      pl_phase = qbpg_pkg::PH_IDLE;
      pl_ticks = '0;
    end
  endfunction

  function automatic void load_next_beep();
    if (pl_beeps == '0) begin
      begin_gap();
    end else if (cur_on_t != '0) begin
      pl_beeps = pl_beeps - 1'b1;
      pl_phase = qbpg_pkg::PH_ON;
      pl_ticks = cur_on_t;
    end else if (cur_off_t != '0) begin
      pl_beeps = pl_beeps - 1'b1;
      pl_phase = qbpg_pkg::PH_OFF;
      pl_ticks = cur_off_t;
    end else begin
      pl_beeps = '0;
      begin_gap();
    end
  endfunction

  function automatic void end_of_phase();
    case (pl_phase)
      qbpg_pkg::PH_ON: begin
        if (cur_off_t != '0) begin
          pl_phase = qbpg_pkg::PH_OFF;
          pl_ticks = cur_off_t;
        end else begin
          load_next_beep();
        end
      end
      qbpg_pkg::PH_OFF: begin
        load_next_beep();
      end
      default: begin
        pl_phase = qbpg_pkg::PH_IDLE;
        pl_ticks = '0;
      end
    endcase
  endfunction

  function automatic void tick_player();
    qbpg_pkg::entry_t e;
    if (pl_phase == qbpg_pkg::PH_IDLE) begin
      if (waiting_requests.size() != 0) begin
        e = waiting_requests.pop_front();
        pl_beeps = e.count;
        cur_on_t = e.on_t;
        cur_off_t = e.off_t;
        load_next_beep();
      end
    end else if (pl_ticks <= 1) begin
      pl_ticks = '0;
      end_of_phase();
    end else begin
      pl_ticks = pl_ticks - 1'b1;
    end
  endfunction

  function automatic qbpg_pkg::out_item_t beeper_status(qbpg_pkg::in_item_t it);
    qbpg_pkg::out_item_t r;
    qbpg_pkg::entry_t e;
    r.dropped = 1'b0;
    if (it.cmd == qbpg_pkg::CMD_ENQUEUE) begin
      if (waiting_requests.size() >= QDEPTH) begin
        r.dropped = 1'b1;
      end else begin
        e.count = it.beep_count;
        e.on_t = ms_to_ticks(it.on_ms);
        e.off_t = ms_to_ticks(it.off_ms);
        waiting_requests.push_back(e);
      end
    end else begin
      tick_player();
    end
    r.buzzer_on = (pl_phase == qbpg_pkg::PH_ON);
    r.queue_level = qbpg_pkg::LEVEL_W'(waiting_requests.size());
    r.busy_res = (pl_phase != qbpg_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic qbpg_pkg::in_item_t tick_item();
    qbpg_pkg::in_item_t it;
    it.cmd = qbpg_pkg::CMD_TICK;
    it.beep_count = qbpg_pkg::COUNT_W'($urandom);
    it.on_ms = qbpg_pkg::MS_W'($urandom);
    it.off_ms = qbpg_pkg::MS_W'($urandom);
    return it;
  endfunction

  function automatic qbpg_pkg::in_item_t request_item(logic [qbpg_pkg::COUNT_W-1:0] cnt,
                                                      logic [qbpg_pkg::MS_W-1:0] on_ms,
                                                      logic [qbpg_pkg::MS_W-1:0] off_ms);
    qbpg_pkg::in_item_t it;
    it.cmd = qbpg_pkg::CMD_ENQUEUE;
    it.beep_count = cnt;
    it.on_ms = on_ms;
    it.off_ms = off_ms;
    return it;
  endfunction

  // Most requests are short so that they play out; the others sweep the full
  // field ranges with sub-tick times or a zero count.
  function automatic qbpg_pkg::in_item_t random_request();
    case ($urandom_range(9))
      0: return request_item(qbpg_pkg::COUNT_W'($urandom), qbpg_pkg::MS_W'($urandom_range(9)),
                             qbpg_pkg::MS_W'($urandom_range(9)));
      1: return request_item('0, qbpg_pkg::MS_W'($urandom), qbpg_pkg::MS_W'($urandom));
      default: return request_item(qbpg_pkg::COUNT_W'($urandom_range(3)),
                                   qbpg_pkg::MS_W'($urandom_range(49)),
                                   qbpg_pkg::MS_W'($urandom_range(49)));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status.push_back(beeper_status(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    qbpg_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("status item with nothing expected: %p", out_data);
          err_cnt++;
        end else begin
          want = expected_status.pop_front();
          if (out_data.buzzer_on !== want.buzzer_on) begin
            $error("buzzer_on: expected %0d, got %0d", want.buzzer_on, out_data.buzzer_on);
            err_cnt++;
          end
          if (out_data.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, out_data.dropped);
            err_cnt++;
          end
          if (out_data.queue_level !== want.queue_level) begin
            $error("queue_level: expected %0d, got %0d", want.queue_level,
                   out_data.queue_level);
            err_cnt++;
          end
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [qbpg_pkg::CFG_AW-3:0] idx, logic [qbpg_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == qbpg_pkg::REG_GAP_MS) begin
      gap_ms_m = val[qbpg_pkg::MS_W-1:0];
    end
    @(negedge clk);
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct, bit hold_off);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) == 0) begin
        repeat (6) pending_items.push_back(random_request());
      end else if ($urandom_range(99) < 12) begin
        pending_items.push_back(random_request());
      end else begin
        pending_items.push_back(tick_item());
      end
    end
    if (hold_off) begin
      hold_seq++;
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_items.push_back(tick_item());
    pending_items.push_back(request_item(8'd0, 16'd0, 16'd0));
    pending_items.push_back(request_item(8'd255, 16'd9, 16'd9));
    pending_items.push_back(request_item(8'd2, 16'd20, 16'd0));
    pending_items.push_back(request_item(8'd1, 16'd0, 16'd30));
    pending_items.push_back(tick_item());
    repeat (13) pending_items.push_back(request_item(8'd1, 16'd10, 16'd10));
    pending_items.push_back(request_item(8'd255, 16'hFFFF, 16'hFFFF));
    pending_items.push_back(tick_item());
    pending_items.push_back(request_item(8'd1, 16'd10, 16'd10));
    pending_items.push_back(tick_item());
    wait_drained();

    run_random(110, 0, 0, 1'b1);
    cfg_write(qbpg_pkg::REG_GAP_MS, 32'd0);
    run_random(110, 81, 0, 1'b0);
    cfg_write(qbpg_pkg::REG_GAP_MS, 32'd9);
    run_random(110, 0, 81, 1'b0);
    cfg_write(qbpg_pkg::REG_GAP_MS, 32'hA5A5_0014);
    run_random(110, 32, 32, 1'b0);
    cfg_write(qbpg_pkg::REG_GAP_MS, 32'd10);
    cfg_write(REG_SPARE, $urandom);
    run_random(110, 0, 0, 1'b0);
    cfg_write(qbpg_pkg::REG_GAP_MS, 32'd35);
    run_random(110, 81, 0, 1'b0);
    cfg_write(qbpg_pkg::REG_GAP_MS, 32'd100);
    run_random(110, 0, 81, 1'b0);

    cfg_write(qbpg_pkg::REG_GAP_MS, 32'h0000_FFFF);
    sender_idle_pct = 32;
    recv_stall_pct = 32;
    repeat (20) pending_items.push_back(tick_item());
    pending_items.push_back(request_item(8'd1, 16'd10, 16'd0));
    repeat (5) pending_items.push_back(tick_item());
    pending_items.push_back(request_item(8'd255, 16'hFFFF, 16'hFFFF));
    repeat (40) pending_items.push_back(tick_item());
    wait_drained();
    repeat (10) @(negedge clk);

    if (err_cnt == 0 && expected_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== queued_beep_pattern_generator_core.f =====
+incdir+rtl
rtl/qbpg_pkg.sv
rtl/qbpg_ram.sv
rtl/qbpg_tick_div.sv
rtl/queued_beep_pattern_generator_core.sv
rtl/qbpg_checker.sv
tb/queued_beep_pattern_generator_core_tb.sv
